[hw/rtl/can_packet_reassembler_core_defines.svh]
`ifndef CAN_PACKET_REASSEMBLER_CORE_DEFINES_SVH
`define CAN_PACKET_REASSEMBLER_CORE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define CPR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpr assertion failed");

// next-cycle implication, checked while out of reset
`define CPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpr assertion failed");

`endif

[hw/rtl/cpr_pkg.sv]
`timescale 1ns / 1ps

package cpr_pkg;

  localparam int FRAME_BYTES  = 8;
  localparam int HEADER_BYTES = 3;
  localparam int IDX_W        = 6;
  localparam int CFG_DATA_W   = 16;

  localparam logic [10:0] RECEIVE_ID_RST  = 11'd546;
  localparam logic [7:0]  START_BYTE_RST  = 8'd170;
  localparam logic [15:0] LENGTH_MASK_RST = 16'd1023;
  localparam logic [6:0]  MIN_LENGTH_RST  = 7'd15;

  typedef enum logic [1:0] {
    CFG_RECEIVE_ID  = 2'd0,
    CFG_START_BYTE  = 2'd1,
    CFG_LENGTH_MASK = 2'd2,
    CFG_MIN_LENGTH  = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [10:0] frame_ident;
    logic [3:0]  frame_count;
    logic [7:0]  byte_0;
    logic [7:0]  byte_1;
    logic [7:0]  byte_2;
    logic [7:0]  byte_3;
    logic [7:0]  byte_4;
    logic [7:0]  byte_5;
    logic [7:0]  byte_6;
    logic [7:0]  byte_7;
  } frame_t;

  typedef struct packed {
    logic [7:0]       packet_byte;
    logic [IDX_W-1:0] byte_index;
    logic             final_res;
  } packet_t;

endpackage

[hw/rtl/can_packet_reassembler_core.sv]
`timescale 1ns / 1ps
// can_packet_reassembler_core
// frame channel: one CAN frame per item (identifier, byte count, eight bytes).
// frames whose identifier differs from receive_id are dropped while idle.
// an accepted frame is scanned one byte per cycle over its count bytes (1 to 8),
// with the frame input closed meanwhile; the scan is the serial loop over the bytes.
// bytes are hunted for start_byte and written into a 64 x 8 packet memory;
// the length word in bytes 1..2 is masked and range checked.
// packet channel: when the packet completes, the frame's remaining bytes are
// dropped and the packet is read from memory one byte per cycle while the
// receiver takes them (a registered memory read, then the output register).
// the frame channel reopens once the reads reach the packet length and the
// state returns to idle; the output register and read stage part the two channels.
// a stalled receiver holds the current item and stops the memory reads.
// cfg channel: always ready, to be written only while the block is idle.
// reset (synchronous): clears the assembly, restores register defaults and
// empties the output; packet memory contents are not cleared.
`include "can_packet_reassembler_core_defines.svh"

module can_packet_reassembler_core
  import cpr_pkg::*;
#(
  parameter int MAX_PACKET = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  frame_valid,
  output logic                  frame_ready,
  input  frame_t                frame,
  output logic                  packet_valid,
  input  logic                  packet_ready,
  output packet_t               packet,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_PACKET);
  localparam int CW = $clog2(MAX_PACKET + 1);

  logic [10:0] receive_id;
  logic [7:0]  start_byte;
  logic [15:0] size_mask;
  logic [6:0]  min_length;

  state_t state, state_next;
  logic [CW-1:0] held_count, held_count_next;
  logic [CW-1:0] expected_total, expected_total_next;
  logic [7:0]    hdr_lo, hdr_lo_next;
  logic [7:0]    fbytes [FRAME_BYTES];
  logic [7:0]    fbytes_next [FRAME_BYTES];
  logic [3:0]    scan_left, scan_left_next;
  logic [CW-1:0] dr_total, dr_total_next;
  logic [CW-1:0] rd_idx;

  logic [7:0]    mem [MAX_PACKET];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    rdata;
  logic          rd_issue;
  logic          rd_pending;
  logic [AW-1:0] pend_idx;
  logic          pend_last;
  logic          move;

  logic [7:0]    cur_byte;
  logic [CW-1:0] held_inc;
  logic [15:0]   word;
  logic          total_ok;
  logic [CW-1:0] exp_new;
  logic [3:0]    sat_count;

  assign cfg_ready = 1'b1;
  assign frame_ready = (state == ST_IDLE);
  assign cur_byte = fbytes[0];
  assign held_inc = held_count + 1'b1;
  assign word = {cur_byte, hdr_lo} & size_mask;
  assign total_ok = (word >= {9'd0, min_length}) && (word <= 16'(MAX_PACKET));
  assign sat_count = (frame.frame_count > 4'(FRAME_BYTES)) ? 4'(FRAME_BYTES)
                                                            : frame.frame_count;
  assign move = rd_pending && (!packet_valid || packet_ready);
  assign rd_issue = (state == ST_DRAIN) && (rd_idx != dr_total) && (!rd_pending || move);

  always_ff @(posedge clk) begin
    if (rst) begin
      receive_id  <= RECEIVE_ID_RST;
      start_byte  <= START_BYTE_RST;
      size_mask   <= LENGTH_MASK_RST;
      min_length  <= MIN_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RECEIVE_ID:  receive_id  <= cfg_data[10:0];
        CFG_START_BYTE:  start_byte  <= cfg_data[7:0];
        CFG_LENGTH_MASK: size_mask   <= cfg_data;
        CFG_MIN_LENGTH:  min_length  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next          = state;
    held_count_next     = held_count;
    expected_total_next = expected_total;
    hdr_lo_next         = hdr_lo;
    fbytes_next         = fbytes;
    scan_left_next      = scan_left;
    dr_total_next       = dr_total;
    mem_we              = 1'b0;
    mem_wa              = held_count[AW-1:0];
    exp_new             = expected_total;
    unique case (state)
      ST_IDLE: begin
        if (frame_valid && frame.frame_ident == receive_id && sat_count != 4'd0) begin
          fbytes_next[0] = frame.byte_0;
          fbytes_next[1] = frame.byte_1;
          fbytes_next[2] = frame.byte_2;
          fbytes_next[3] = frame.byte_3;
          fbytes_next[4] = frame.byte_4;
          fbytes_next[5] = frame.byte_5;
          fbytes_next[6] = frame.byte_6;
          fbytes_next[7] = frame.byte_7;
          scan_left_next = sat_count;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        for (int j = 0; j < FRAME_BYTES - 1; j++) begin
          fbytes_next[j] = fbytes[j+1];
        end
        scan_left_next = scan_left - 1'b1;
        if (scan_left == 4'd1) begin
          state_next = ST_IDLE;
        end
        if (held_count == '0 || held_count >= CW'(MAX_PACKET)) begin
          held_count_next     = '0;
          expected_total_next = '0;
          if (cur_byte == start_byte) begin
            mem_we          = 1'b1;
            mem_wa          = '0;
            held_count_next = CW'(1);
          end
        end else begin
          mem_we          = 1'b1;
          held_count_next = held_inc;
          if (held_count == CW'(1)) begin
            hdr_lo_next = cur_byte;
          end
          if (held_inc == CW'(HEADER_BYTES)) begin
            exp_new = total_ok ? CW'(word) : '0;
            if (!total_ok) begin
              held_count_next = '0;
            end
          end
          expected_total_next = exp_new;
          if (exp_new != '0 && held_inc >= exp_new) begin
            dr_total_next       = exp_new;
            held_count_next     = '0;
            expected_total_next = '0;
            state_next          = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (rd_idx == dr_total) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      held_count     <= '0;
      expected_total <= '0;
    end else begin
      state          <= state_next;
      held_count     <= held_count_next;
      expected_total <= expected_total_next;
    end
  end

  always_ff @(posedge clk) begin
    hdr_lo    <= hdr_lo_next;
    fbytes    <= fbytes_next;
    scan_left <= scan_left_next;
    dr_total  <= dr_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (state == ST_SCAN && state_next == ST_DRAIN) begin
      rd_idx <= '0;
    end else if (rd_issue) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= cur_byte;
    end
    if (rd_issue) begin
      rdata <= mem[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else if (rd_issue) begin
      rd_pending <= 1'b1;
    end else if (move) begin
      rd_pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      pend_idx  <= rd_idx[AW-1:0];
      pend_last <= (CW'(rd_idx + 1'b1) == dr_total);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_valid <= 1'b0;
    end else if (move) begin
      packet_valid <= 1'b1;
    end else if (packet_ready) begin
      packet_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      packet.packet_byte <= rdata;
      packet.byte_index  <= IDX_W'(pend_idx);
      packet.final_res   <= pend_last;
    end
  end

  `CPR_ASSERT_NOW(a_held_range, 1'b1, held_count <= CW'(MAX_PACKET))
  `CPR_ASSERT_NOW(a_mem_one_port, mem_we, !rd_issue)
  `CPR_ASSERT_NEXT(a_read_lands, rd_issue, rd_pending)
  `CPR_ASSERT_NOW(a_drain_nonempty, state == ST_DRAIN, dr_total != '0)

endmodule
